// ----- hw/rtl/generational_slot_allocator_assert.svh -----
// Assertion macros used by the checker file of the slot allocator.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GSA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/gsa_pkg.sv -----
// Package with the types and constants of the generational slot allocator.
package gsa_pkg;

    localparam int SLOT_IDX_W = 10;
    localparam int TAG_W      = 16;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATE  = 2'd0,
        KIND_MARK    = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_QUERY   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } state_t;

endpackage

// ----- hw/rtl/generational_slot_allocator.sv -----
// Generational slot allocator: hands out and checks (slot, generation) handles.
// A result is registered in EXEC, after the READ state that follows acceptance of
// its input beat; s_tready is high only in IDLE, so one beat is in flight. The
// free-queue read feeds the slot-table read; a stalled result holds the next beat in EXEC.
// Reset clears the FSM, queue pointers, counters and output valid; the memories
// are not cleared, since slots at or above the fresh count read as never used.
module generational_slot_allocator
    import gsa_pkg::*;
#(
    parameter int SLOT_COUNT = 1024,
    parameter int TAG_BITS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // slot_index [9:0], tag [25:10], zero [31:26]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind [1:0]
    input  logic [KIND_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // handle_slot [9:0], handle_tag [25:10], is_alive [26], zero [31:27]
    output logic [M_TDATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [STATUS_W-1:0]  m_tuser
);

    localparam int SLOT_W  = $clog2(SLOT_COUNT);
    localparam int CNT_W   = SLOT_W + 1;
    localparam int ENTRY_W = TAG_BITS + 2;
    localparam int CMP_W   = (TAG_BITS > TAG_W) ? TAG_BITS : TAG_W;

    state_t                  state_reg, state_next;
    kind_t                   kind_reg;
    logic [SLOT_IDX_W-1:0]   idx_in_reg;
    logic [TAG_W-1:0]        tag_in_reg;
    logic [SLOT_W-1:0]       head_reg, tail_reg;
    logic [CNT_W-1:0]        count_reg, fresh_reg;
    logic                    m_valid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]     m_tuser_reg;

    logic                    out_free, exec_fire;
    logic [SLOT_W-1:0]       idx_slot, q_slot, tag_raddr;
    logic [ENTRY_W-1:0]      entry;
    logic [TAG_BITS-1:0]     gen;
    logic                    live, marked, in_range, valid_slot, alive;

    logic [SLOT_IDX_W-1:0]   res_slot;
    logic [TAG_W-1:0]        res_tag;
    status_t                 res_status;
    logic                    tag_we, q_we, do_pop, do_push, do_fresh;
    logic [SLOT_W-1:0]       tag_waddr;
    logic [ENTRY_W-1:0]      tag_wdata;

    gsa_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_queue (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (tail_reg),
        .wdata (idx_slot),
        .raddr (head_reg),
        .rdata (q_slot)
    );

    gsa_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_COUNT)) u_table (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (entry)
    );

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_EXEC;
            S_EXEC: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        exec_fire = 1'b0;
        case (state_reg)
            S_IDLE:  s_tready  = 1'b1;
            S_EXEC:  exec_fire = out_free;
            default: begin
                s_tready  = 1'b0;
                exec_fire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg   <= kind_t'(s_tuser);
            idx_in_reg <= s_tdata[SLOT_IDX_W-1:0];
            tag_in_reg <= s_tdata[SLOT_IDX_W +: TAG_W];
        end
    end

    assign idx_slot   = SLOT_W'(idx_in_reg);
    assign in_range   = 32'(idx_in_reg) < 32'(SLOT_COUNT);
    assign valid_slot = in_range && ({1'b0, idx_slot} < fresh_reg);

    always_comb begin
        if (state_reg == S_IDLE) begin
            tag_raddr = SLOT_W'(s_tdata[SLOT_IDX_W-1:0]);
        end else if (kind_reg == KIND_CREATE) begin
            tag_raddr = q_slot;
        end else begin
            tag_raddr = idx_slot;
        end
    end

    assign gen    = entry[TAG_BITS-1:0];
    assign live   = entry[TAG_BITS];
    assign marked = entry[TAG_BITS+1];
    assign alive  = valid_slot && live && (CMP_W'(gen) == CMP_W'(tag_in_reg));

    always_comb begin
        res_slot   = idx_in_reg;
        res_tag    = valid_slot ? TAG_W'(gen) : '0;
        res_status = ST_DONE;
        tag_we     = 1'b0;
        tag_waddr  = idx_slot;
        tag_wdata  = entry;
        q_we       = 1'b0;
        do_pop     = 1'b0;
        do_push    = 1'b0;
        do_fresh   = 1'b0;
        case (kind_reg)
            KIND_CREATE: begin
                if (count_reg != '0) begin
                    res_slot  = SLOT_IDX_W'(q_slot);
                    res_tag   = TAG_W'(gen);
                    tag_we    = 1'b1;
                    tag_waddr = q_slot;
                    tag_wdata = {1'b0, 1'b1, gen};
                    do_pop    = 1'b1;
                end else if (fresh_reg < CNT_W'(SLOT_COUNT)) begin
                    res_slot  = SLOT_IDX_W'(fresh_reg);
                    res_tag   = TAG_W'(TAG_BITS'(1));
                    tag_we    = 1'b1;
                    tag_waddr = fresh_reg[SLOT_W-1:0];
                    tag_wdata = {1'b0, 1'b1, TAG_BITS'(1)};
                    do_fresh  = 1'b1;
                end else begin
                    res_slot   = '0;
                    res_tag    = '0;
                    res_status = ST_FULL;
                end
            end
            KIND_MARK: begin
                if (alive && !marked) begin
                    tag_we    = 1'b1;
                    tag_wdata = {1'b1, 1'b1, gen};
                end else begin
                    res_status = ST_IGNORED;
                end
            end
            KIND_RELEASE: begin
                if (valid_slot && live && (count_reg < CNT_W'(SLOT_COUNT))) begin
                    tag_we    = 1'b1;
                    tag_wdata = {1'b0, 1'b0, gen + TAG_BITS'(1)};
                    q_we      = 1'b1;
                    do_push   = 1'b1;
                end else begin
                    res_status = ST_IGNORED;
                end
            end
            KIND_QUERY: res_status = ST_DONE;
            default:    res_status = ST_DONE;
        endcase
        tag_we = tag_we && exec_fire;
        q_we   = q_we && exec_fire;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            fresh_reg <= '0;
        end else if (exec_fire) begin
            if (do_pop) begin
                head_reg  <= (head_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0 : head_reg + 1'b1;
                count_reg <= count_reg - 1'b1;
            end
            if (do_push) begin
                tail_reg  <= (tail_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0 : tail_reg + 1'b1;
                count_reg <= count_reg + 1'b1;
            end
            if (do_fresh) begin
                fresh_reg <= fresh_reg + 1'b1;
            end
        end
    end

    assign m_tdata_next = M_TDATA_W'({(kind_reg != KIND_CREATE) && alive, res_tag, res_slot});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= res_status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- hw/rtl/gsa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/gsa_checker.sv -----
// Port-level assertion checker for the slot allocator and its bind statement.
`include "generational_slot_allocator_assert.svh"

module gsa_checker
    import gsa_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [KIND_W-1:0]    s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    logic in_beat, out_full, status_ok;

    assign in_beat   = s_tvalid && s_tready;
    assign out_full  = m_tvalid && (m_tuser == ST_FULL);
    assign status_ok = m_tuser inside {ST_DONE, ST_IGNORED, ST_FULL};

    `GSA_ASSERT_NOW(a_status_code, aclk, aresetn, m_tvalid, status_ok, "bad status code")
    `GSA_ASSERT_NOW(a_full_zero, aclk, aresetn, out_full, m_tdata == '0, "full beat not zero")
    `GSA_ASSERT_NEXT(a_one_item, aclk, aresetn, in_beat, !s_tready, "second beat taken early")
    `GSA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
